// ----- rtl/pibi_pkg.sv -----
`timescale 1ns / 1ps
package pibi_pkg;
    localparam int MaxBits  = 164;
    localparam int MaxBytes = MaxBits / 8;
    localparam int IdxW     = 8;
    localparam int CntW     = 5;

    localparam logic [1:0] REG_MSG_BYTES = 2'd0;
    localparam logic [1:0] REG_IL_EN     = 2'd1;
    localparam logic [1:0] REG_DIR       = 2'd2;

    function automatic logic [7:0] il_table(input logic [7:0] m);
        logic [7:0] t [0:163];
        t = '{
            8'd0,8'd2,8'd4,8'd7,8'd9,8'd14,8'd19,8'd20,8'd24,8'd25,8'd26,8'd28,8'd31,8'd34,
            8'd42,8'd45,8'd49,8'd50,8'd51,8'd53,8'd54,8'd56,8'd58,8'd59,8'd61,8'd62,8'd65,
            8'd66,8'd67,8'd69,8'd70,8'd71,8'd72,8'd76,8'd77,8'd81,8'd82,8'd83,8'd87,8'd88,
            8'd89,8'd91,8'd93,8'd95,8'd98,8'd101,8'd104,8'd106,8'd108,8'd110,8'd111,8'd113,
            8'd115,8'd118,8'd119,8'd120,8'd122,8'd123,8'd126,8'd127,8'd129,8'd132,8'd134,
            8'd138,8'd139,8'd140,8'd1,8'd3,8'd5,8'd8,8'd10,8'd15,8'd21,8'd27,8'd29,8'd32,
            8'd35,8'd43,8'd46,8'd52,8'd55,8'd57,8'd60,8'd63,8'd68,8'd73,8'd78,8'd84,8'd90,
            8'd92,8'd94,8'd96,8'd99,8'd102,8'd105,8'd107,8'd109,8'd112,8'd114,8'd116,8'd121,
            8'd124,8'd128,8'd130,8'd133,8'd135,8'd141,8'd6,8'd11,8'd16,8'd22,8'd30,8'd33,
            8'd36,8'd44,8'd47,8'd64,8'd74,8'd79,8'd85,8'd97,8'd100,8'd103,8'd117,8'd125,
            8'd131,8'd136,8'd142,8'd12,8'd17,8'd23,8'd37,8'd48,8'd75,8'd80,8'd86,8'd137,
            8'd143,8'd13,8'd18,8'd38,8'd144,8'd39,8'd145,8'd40,8'd146,8'd41,8'd147,8'd148,
            8'd149,8'd150,8'd151,8'd152,8'd153,8'd154,8'd155,8'd156,8'd157,8'd158,8'd159,
            8'd160,8'd161,8'd162,8'd163};
        if (m < 8'(MaxBits)) begin
            return t[m];
        end
        return 8'd0;
    endfunction
endpackage

// ----- rtl/pibi_perm_builder.sv -----
`timescale 1ns / 1ps
// Walks the table one entry a cycle and writes the pattern memory (an identity pattern when interleaving is off).
module pibi_perm_builder import pibi_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [7:0]      k_bits,
    input  logic            il_en,
    output logic            busy,
    output logic            wr_en,
    output logic [IdxW-1:0] wr_addr,
    output logic [IdxW-1:0] wr_data
);
    logic [7:0] m_reg, m_next, k_reg, k_next;
    logic       busy_reg, busy_next;
    logic [7:0] base, tv;

    assign base = 8'(MaxBits) - k_bits;
    assign tv   = il_table(m_reg);

    always_comb begin
        m_next = m_reg; k_next = k_reg; busy_next = busy_reg;
        wr_en = 1'b0; wr_addr = k_reg; wr_data = k_reg;
        if (start) begin
            m_next = '0; k_next = '0; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (k_reg >= k_bits) begin
                busy_next = 1'b0;
            end else if (il_en && m_reg < 8'(MaxBits)) begin
                m_next = m_reg + 8'd1;
                if (tv >= base) begin
                    wr_en = 1'b1; wr_data = tv - base; k_next = k_reg + 8'd1;
                end
            end else begin
                wr_en = 1'b1; k_next = k_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_reg <= '0; k_reg <= '0; busy_reg <= 1'b1;
        end else begin
            m_reg <= m_next; k_reg <= k_next; busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;
endmodule

// ----- rtl/polar_input_bit_interleaver_core.sv -----
`timescale 1ns / 1ps
// Polar input bit interleaver, K = 8*msg_bytes up to 160 bits. Bytes are
// written into a byte memory; after the last byte the block walks the pattern
// memory one output bit per cycle and pauses after each output byte until
// it is taken. Input reopens once the last output byte is taken. Scatter
// mode first sweeps the pattern memory to write an inverse. After reset or
// any register write a pattern rebuild runs, during which no request is
// accepted.
module polar_input_bit_interleaver_core import pibi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_out
);
    typedef enum logic [2:0] {S_IN, S_INV, S_RD, S_OUT} state_t;

    logic [4:0] msg_bytes_reg;
    logic       il_en_reg, dir_reg;
    logic       wr_cfg;
    logic [4:0] nb;
    logic [7:0] k_bits;

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;
    always_comb begin
        case (paddr[3:2])
            REG_MSG_BYTES: prdata = {27'd0, msg_bytes_reg};
            REG_IL_EN:     prdata = {31'd0, il_en_reg};
            REG_DIR:       prdata = {31'd0, dir_reg};
            default:       prdata = '0;
        endcase
    end
    assign nb = (msg_bytes_reg == 5'd0) ? 5'd1 :
                (msg_bytes_reg > 5'(MaxBytes)) ? 5'(MaxBytes) : msg_bytes_reg;
    assign k_bits = {nb, 3'b000};

    logic cfg_hit;
    assign cfg_hit = wr_cfg && paddr[1:0] == 2'b00 &&
                     (paddr[3:2] == REG_MSG_BYTES || paddr[3:2] == REG_IL_EN ||
                      paddr[3:2] == REG_DIR);

    logic            b_busy, b_we;
    logic [IdxW-1:0] b_addr, b_data;
    pibi_perm_builder u_build (
        .aclk(aclk), .aresetn(aresetn), .start(cfg_hit), .k_bits(k_bits),
        .il_en(il_en_reg), .busy(b_busy), .wr_en(b_we), .wr_addr(b_addr),
        .wr_data(b_data)
    );

    // memories
    logic [IdxW-1:0] perm_mem [0:MaxBits-1];
    logic [IdxW-1:0] inv_mem  [0:MaxBits-1];
    logic [7:0]      byte_mem [0:MaxBytes-1];
    logic [IdxW-1:0] perm_q, inv_q;
    logic [7:0]      byte_q;
    logic [IdxW-1:0] p_raddr, i_waddr, i_wdata, i_raddr;
    logic            i_we;
    logic [4:0]      by_raddr;

    always_ff @(posedge aclk) begin
        if (b_we) perm_mem[b_addr] <= b_data;
        perm_q <= perm_mem[p_raddr];
        if (i_we) inv_mem[i_waddr] <= i_wdata;
        inv_q <= inv_mem[i_raddr];
        byte_q <= byte_mem[by_raddr];
    end

    state_t     state_reg;
    logic [4:0] cnt_reg;
    logic [7:0] idx_reg;
    logic       rv_reg;
    logic [7:0] ridx_reg;
    logic [7:0] acc_reg;
    logic       ov_reg;
    logic [7:0] ob_reg;
    logic       ol_reg;
    logic [7:0] src;
    logic       rd_stall;

    assign s_ready  = state_reg == S_IN && !b_busy;
    assign m_valid  = ov_reg;
    assign m_out_byte = ob_reg;
    assign m_last_out = ol_reg;

    assign p_raddr  = idx_reg;
    assign i_raddr  = idx_reg;
    assign i_we     = state_reg == S_INV && rv_reg;
    assign i_waddr  = perm_q;
    assign i_wdata  = ridx_reg;
    // source bit index of output bit ridx: gather p[i], scatter inverse
    assign src      = dir_reg ? inv_q : perm_q;
    assign by_raddr = (state_reg == S_RD) ? src[7:3] : 5'd0;
    // pace one output byte per 8 bits; stall while a byte waits
    assign rd_stall = idx_reg[2:0] == 3'd0 && idx_reg != 8'd0 &&
                      (ov_reg || rv_reg || bv_reg);

    // bit-select from the registered byte read, with the bit index registered alongside
    logic [2:0] sbit_reg;
    logic       bv_reg;
    logic [7:0] bidx_reg;
    logic       obit;
    assign obit = byte_q[3'd7 - sbit_reg];

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) byte_mem[cnt_reg] <= s_data_byte;
        sbit_reg <= src[2:0];
        bidx_reg <= ridx_reg;
        if (bv_reg) acc_reg <= {acc_reg[6:0], obit};
        if (bv_reg && bidx_reg[2:0] == 3'd7) begin
            ob_reg <= {acc_reg[6:0], obit};
            ol_reg <= bidx_reg[7:3] == nb - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_bytes_reg <= 5'd20; il_en_reg <= 1'b1; dir_reg <= 1'b0;
            state_reg <= S_IN; cnt_reg <= '0; idx_reg <= '0; rv_reg <= 1'b0;
            ridx_reg <= '0; bv_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            if (cfg_hit) begin
                case (paddr[3:2])
                    REG_MSG_BYTES: msg_bytes_reg <= pwdata[4:0];
                    REG_IL_EN:     il_en_reg <= pwdata[0];
                    REG_DIR:       dir_reg <= pwdata[0];
                    default:       ;
                endcase
                cnt_reg <= '0;
            end
            if (bv_reg && bidx_reg[2:0] == 3'd7) begin
                ov_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                ov_reg <= 1'b0;
            end
            rv_reg <= (state_reg == S_INV && idx_reg < k_bits) ||
                      (state_reg == S_RD && idx_reg < k_bits && !rd_stall);
            ridx_reg <= idx_reg;
            bv_reg <= state_reg == S_RD && rv_reg;
            case (state_reg)
                S_IN: begin
                    if (s_valid && s_ready) begin
                        if (cnt_reg + 5'd1 >= nb) begin
                            cnt_reg <= '0; idx_reg <= '0;
                            state_reg <= dir_reg ? S_INV : S_RD;
                        end else begin
                            cnt_reg <= cnt_reg + 5'd1;
                        end
                    end
                end
                S_INV: begin
                    if (idx_reg < k_bits) begin
                        idx_reg <= idx_reg + 8'd1;
                    end else if (!rv_reg) begin
                        idx_reg <= '0; state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    if (idx_reg < k_bits) begin
                        if (!rd_stall) begin
                            idx_reg <= idx_reg + 8'd1;
                        end
                    end else if (!rv_reg && !bv_reg) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!ov_reg) state_reg <= S_IN;
                end
                default: state_reg <= S_IN;
            endcase
        end
    end

    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        b_busy |-> !s_ready) else $error("request accepted during rebuild");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (bv_reg && bidx_reg[2:0] == 3'd7) |-> (!ov_reg || m_ready))
        else $error("output byte overwritten");
    a_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid || state_reg == S_IN)
        else $error("input open during emit");
endmodule
